// ===== hw/rtl/set_assoc_cache_tag_lookup_assert.svh =====
// Assertion macros shared by the tag lookup RTL.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned OFFSET_W      = 4;
  localparam int unsigned SEED_W        = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned WAY_OUT_W     = 2;
  localparam int unsigned SET_OUT_W     = 6;
  localparam int unsigned MOD_W         = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned SETS_DEFAULT  = 64;
  localparam int unsigned WAYS_DEFAULT  = 4;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd5;
  localparam logic [SEED_W-1:0]   SEED_RESET   = 16'd44257;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'b1;

  typedef enum logic {
    BK_IDLE,
    BK_LOOK
  } back_state_e;

  typedef struct packed {
    logic                  offset_we;
    logic                  seed_we;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef logic [MOD_W-1:0] byte_mod_tbl_t [256];

  // floor(log2(sets))
  function automatic int unsigned idx_bits(int unsigned sets);
    int unsigned b;
    b = 0;
    for (int unsigned i = 1; i < 32; i++) begin
      if ((64'd1 << i) <= 64'(sets)) b = i;
    end
    return b;
  endfunction

  function automatic int unsigned set_bits(int unsigned sets);
    return (idx_bits(sets) > 0) ? idx_bits(sets) : 1;
  endfunction

  function automatic int unsigned way_bits(int unsigned ways);
    return (ways > 1) ? $clog2(ways) : 1;
  endfunction

  // Residues of one byte of a 16-bit value modulo k: entry v holds v mod k for the
  // low byte, or (v * 256) mod k for the high byte. Built by stepping, no divide.
  function automatic byte_mod_tbl_t byte_mod_tbl(int unsigned k, bit high_byte);
    byte_mod_tbl_t tbl;
    int unsigned   step;
    int unsigned   acc;
    step = 0;
    if (high_byte) begin
      for (int i = 0; i < 256; i++) begin
        step = step + 1;
        if (step >= k) step = 0;
      end
    end else begin
      step = (k > 1) ? 1 : 0;
    end
    acc = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = MOD_W'(acc);
      acc = acc + step;
      if (acc >= k) acc = acc - k;
    end
    return tbl;
  endfunction

endpackage

// ===== hw/rtl/sacl_ram.sv =====
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sacl_front.sv =====
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_assert.svh"

module sacl_front #(
  parameter int unsigned SETS = sacl_pkg::SETS_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sacl_pkg::cfg_wr_t                       cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [sacl_pkg::ADDR_W-1:0]             address_i,
  output logic                                    q_valid_o,
  input  logic                                    q_pop_i,
  output logic [sacl_pkg::set_bits(SETS)-1:0]     q_set_o,
  output logic [sacl_pkg::ADDR_W-sacl_pkg::idx_bits(SETS)-1:0] q_tag_o
);

  localparam int unsigned IB      = sacl_pkg::idx_bits(SETS);
  localparam int unsigned SET_W   = sacl_pkg::set_bits(SETS);
  localparam int unsigned TAG_W   = sacl_pkg::ADDR_W - IB;
  localparam int unsigned ENTRY_W = SET_W + TAG_W;
  localparam int unsigned DEPTH   = sacl_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  logic [sacl_pkg::OFFSET_W-1:0] offset_q;
  logic [sacl_pkg::ADDR_W-1:0]   shifted;
  logic [SET_W-1:0]              set_d;
  logic [TAG_W-1:0]              tag_d;
  logic [ENTRY_W-1:0]            entry_q [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          push;

  // Split the address: drop the block offset, then set index, then tag.
  assign shifted = address_i >> offset_q;
  assign set_d   = (IB > 0) ? shifted[SET_W-1:0] : '0;
  assign tag_d   = TAG_W'(shifted >> IB);

  assign in_stall_o = (cnt_q == CNT_W'(DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign {q_set_o, q_tag_o} = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= sacl_pkg::OFFSET_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_i.offset_we) offset_q <= cfg_i.data[sacl_pkg::OFFSET_W-1:0];
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= {set_d, tag_d};
  end

  `SACL_ASSERT_NOW(a_pop_nonempty, q_pop_i, cnt_q != '0, "queue popped while empty")

endmodule

// ===== hw/rtl/sacl_back.sv =====
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_assert.svh"

module sacl_back #(
  parameter int unsigned SETS = sacl_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS = sacl_pkg::WAYS_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sacl_pkg::cfg_wr_t                       cfg_i,
  input  logic                                    q_valid_i,
  output logic                                    q_pop_o,
  input  logic [sacl_pkg::set_bits(SETS)-1:0]     q_set_i,
  input  logic [sacl_pkg::ADDR_W-sacl_pkg::idx_bits(SETS)-1:0] q_tag_i,
  output logic                                    ram_re_o,
  output logic [sacl_pkg::set_bits(SETS)-1:0]     ram_raddr_o,
  output logic                                    ram_we_o,
  output logic [sacl_pkg::set_bits(SETS)-1:0]     ram_waddr_o,
  output logic [WAYS*(sacl_pkg::ADDR_W-sacl_pkg::idx_bits(SETS))-1:0] ram_wdata_o,
  input  logic [WAYS*(sacl_pkg::ADDR_W-sacl_pkg::idx_bits(SETS))-1:0] ram_rdata_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    hit_o,
  output logic [sacl_pkg::WAY_OUT_W-1:0]          way_o,
  output logic [sacl_pkg::SET_OUT_W-1:0]          set_index_o,
  output logic [sacl_pkg::COUNT_W-1:0]            hit_count_o,
  output logic [sacl_pkg::COUNT_W-1:0]            miss_count_o
);

  localparam int unsigned IB    = sacl_pkg::idx_bits(SETS);
  localparam int unsigned SET_W = sacl_pkg::set_bits(SETS);
  localparam int unsigned TAG_W = sacl_pkg::ADDR_W - IB;
  localparam int unsigned WAY_W = sacl_pkg::way_bits(WAYS);
  localparam int unsigned CNT_W = $clog2(WAYS + 1);
  localparam int unsigned NSETS = 2 ** IB;
  localparam int unsigned ROW_W = WAYS * TAG_W;
  localparam int unsigned SUM_W = sacl_pkg::MOD_W + 1;

  sacl_pkg::back_state_e state_q, state_d;

  logic [SET_W-1:0]                cur_set_q;
  logic [TAG_W-1:0]                cur_tag_q;
  logic [WAY_W-1:0]                res_q [WAYS];
  logic [WAY_W-1:0]                res_d [WAYS];
  logic [sacl_pkg::SEED_W-1:0]     lfsr_q;
  logic [sacl_pkg::SEED_W-1:0]     lfsr_step;
  logic [sacl_pkg::COUNT_W-1:0]    hits_q, misses_q;
  logic [WAYS-1:0]                 valid_q [NSETS];
  logic                            out_valid_q;
  logic                            out_hit_q;
  logic [WAY_W-1:0]                out_way_q;
  logic [SET_W-1:0]                out_set_q;

  logic                            commit;
  logic [WAYS-1:0]                 valid_row;
  logic [WAYS-1:0]                 hit_vec;
  logic                            hit;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                victim;
  logic [WAY_W-1:0]                way_sel;
  logic [ROW_W-1:0]                wr_row;

  // Residues of the LFSR modulo every candidate count, one table pair per divisor.
  for (genvar K = 1; K <= WAYS; K++) begin : g_res
    localparam sacl_pkg::byte_mod_tbl_t LoTbl = sacl_pkg::byte_mod_tbl(K, 1'b0);
    localparam sacl_pkg::byte_mod_tbl_t HiTbl = sacl_pkg::byte_mod_tbl(K, 1'b1);
    logic [SUM_W-1:0] sum;
    assign sum = {1'b0, LoTbl[lfsr_q[7:0]]} + {1'b0, HiTbl[lfsr_q[15:8]]};
    assign res_d[K-1] = (sum >= (SUM_W)'(K)) ? WAY_W'(sum - (SUM_W)'(K)) : WAY_W'(sum);
  end

  assign lfsr_step = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  assign valid_row = valid_q[cur_set_q];

  always_comb begin : lookup
    logic [WAYS-1:0]  inv;
    logic [CNT_W-1:0] n_inv;
    logic [CNT_W-1:0] below;
    logic [WAY_W-1:0] pick;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid_row[i] && (ram_rdata_i[i*TAG_W +: TAG_W] == cur_tag_q);
    end
    hit     = |hit_vec;
    hit_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way = WAY_W'(i);
    end
    // Victim: pick among invalid ways, or among all ways when the set is full.
    inv    = ~valid_row;
    n_inv  = CNT_W'($countones(inv));
    pick   = (n_inv == '0) ? '0 : res_q[WAY_W'(n_inv - 1'b1)];
    below  = '0;
    victim = res_q[WAYS-1];
    if (n_inv != '0) begin
      victim = '0;
      for (int i = 0; i < WAYS; i++) begin
        below = CNT_W'($countones(inv & ((WAYS'(1) << i) - WAYS'(1))));
        if (inv[i] && (below == CNT_W'(pick))) victim = WAY_W'(i);
      end
    end
    way_sel = hit ? hit_way : victim;
    wr_row  = ram_rdata_i;
    for (int i = 0; i < WAYS; i++) begin
      if (victim == WAY_W'(i)) wr_row[i*TAG_W +: TAG_W] = cur_tag_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacl_pkg::BK_IDLE: begin
        if (q_valid_i) state_d = sacl_pkg::BK_LOOK;
      end
      sacl_pkg::BK_LOOK: begin
        if (!out_valid_q || !out_stall_i) state_d = sacl_pkg::BK_IDLE;
      end
      default: state_d = sacl_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o  = 1'b0;
    ram_re_o = 1'b0;
    commit   = 1'b0;
    unique case (state_q)
      sacl_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ram_re_o = 1'b1;
        end
      end
      sacl_pkg::BK_LOOK: begin
        commit = !out_valid_q || !out_stall_i;
      end
      default: begin
        commit = 1'b0;
      end
    endcase
  end

  assign ram_raddr_o = q_set_i;
  assign ram_we_o    = commit && !hit;
  assign ram_waddr_o = cur_set_q;
  assign ram_wdata_o = wr_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacl_pkg::BK_IDLE;
      lfsr_q      <= sacl_pkg::SEED_RESET;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '{default: '0};
    end else begin
      state_q <= state_d;
      if (cfg_i.seed_we) begin
        lfsr_q <= (cfg_i.data == '0) ? sacl_pkg::SEED_RESET : cfg_i.data;
      end else if (commit && !hit) begin
        lfsr_q <= lfsr_step;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (hit) begin
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else begin
          if (misses_q != '1) misses_q <= misses_q + 1'b1;
          valid_q[cur_set_q][victim] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re_o) begin
      cur_set_q <= q_set_i;
      cur_tag_q <= q_tag_i;
      res_q     <= res_d;
    end
    if (commit) begin
      out_hit_q <= hit;
      out_way_q <= way_sel;
      out_set_q <= cur_set_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign way_o        = (sacl_pkg::WAY_OUT_W)'(out_way_q);
  assign set_index_o  = (sacl_pkg::SET_OUT_W)'(out_set_q);
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

  `SACL_ASSERT_NEXT(a_read_then_look, ram_re_o, state_q == sacl_pkg::BK_LOOK, "read not followed by lookup")
  `SACL_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr_q != '0, "replacement LFSR locked at zero")
  `SACL_ASSERT_NEXT(a_counts_hold, out_valid_q && out_stall_i, hits_q == $past(hits_q) && misses_q == $past(misses_q), "counters moved under stalled result")
  `SACL_ASSERT_NOW(a_write_on_miss, ram_we_o, state_q == sacl_pkg::BK_LOOK && !hit, "tag write outside a miss")

endmodule

// ===== hw/rtl/set_assoc_cache_tag_lookup.sv =====
`timescale 1ns / 1ps
// Tag lookup for a set-associative cache with pseudo-random replacement.
// Request channel: address_i with in_valid_i / in_stall_o. A request is taken
// at a clock edge with valid high and stall low. Result channel: hit_o, way_o,
// set_index_o, hit_count_o, miss_count_o with out_valid_o / out_stall_i.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (offset_bits, random_seed); write only while no request is in flight.
// A taken request is queued; the lookup side pops it and reads the tag RAM
// row, then compares, fills a way on a miss and registers the result. It
// takes the next request from the queue only once that result is committed.
// A two-entry queue sits between address split and lookup, so it holds up to
// two requests while a result waits; in_stall_o rises when it is full.
// On a stalled result the result holds and the lookup side waits.
// Reset: all ways invalid (no clearing pass, valid bits reset at once),
// counters zero, offset_bits 5, LFSR 44257. Tag RAM contents are not reset.
module set_assoc_cache_tag_lookup #(
  parameter int unsigned SETS = sacl_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS = sacl_pkg::WAYS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sacl_pkg::ADDR_W-1:0]        address_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic [sacl_pkg::WAY_OUT_W-1:0]     way_o,
  output logic [sacl_pkg::SET_OUT_W-1:0]     set_index_o,
  output logic [sacl_pkg::COUNT_W-1:0]       hit_count_o,
  output logic [sacl_pkg::COUNT_W-1:0]       miss_count_o
);

  localparam int unsigned IB    = sacl_pkg::idx_bits(SETS);
  localparam int unsigned SET_W = sacl_pkg::set_bits(SETS);
  localparam int unsigned TAG_W = sacl_pkg::ADDR_W - IB;
  localparam int unsigned ROW_W = WAYS * TAG_W;
  localparam int unsigned NSETS = 2 ** IB;

  sacl_pkg::cfg_wr_t cfg_wr;

  logic             q_valid;
  logic             q_pop;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;

  logic             ram_re, ram_we;
  logic [SET_W-1:0] ram_raddr, ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  // Decode register writes; both sides see the same data.
  always_comb begin
    cfg_wr      = '0;
    cfg_wr.data = cfg_data_i;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sacl_pkg::CFG_OFFSET_BITS: cfg_wr.offset_we = 1'b1;
        sacl_pkg::CFG_RANDOM_SEED: cfg_wr.seed_we   = 1'b1;
        default: cfg_wr.offset_we = 1'b0;
      endcase
    end
  end

  // Front: split addresses and queue them.
  sacl_front #(
    .SETS(SETS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .address_i  (address_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_set_o    (q_set),
    .q_tag_o    (q_tag)
  );

  // Tag RAM: one row per set holding the tags of all ways.
  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NSETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back: read the set, compare, fill on a miss, count, drive the result.
  sacl_back #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_set_i      (q_set),
    .q_tag_i      (q_tag),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .way_o        (way_o),
    .set_index_o  (set_index_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_SETS  = sacl_pkg::SETS_DEFAULT;
  localparam int unsigned NUM_WAYS  = sacl_pkg::WAYS_DEFAULT;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned RECENT_MAX = 16;

  // One result as the block should present it
  typedef struct {
    logic                           hit;
    logic [sacl_pkg::WAY_OUT_W-1:0] way;
    logic [sacl_pkg::SET_OUT_W-1:0] set_index;
    logic [sacl_pkg::COUNT_W-1:0]   hit_count;
    logic [sacl_pkg::COUNT_W-1:0]   miss_count;
  } lookup_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [sacl_pkg::ADDR_W-1:0]     address_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic                            hit_o;
  logic [sacl_pkg::WAY_OUT_W-1:0]  way_o;
  logic [sacl_pkg::SET_OUT_W-1:0]  set_index_o;
  logic [sacl_pkg::COUNT_W-1:0]    hit_count_o;
  logic [sacl_pkg::COUNT_W-1:0]    miss_count_o;

  set_assoc_cache_tag_lookup uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .way_o        (way_o),
    .set_index_o  (set_index_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

  // Shadow copy of the tag store, counters, LFSR and registers
  logic [25:0]                    shadow_tags  [NUM_SETS][NUM_WAYS];
  bit                             shadow_valid [NUM_SETS][NUM_WAYS];
  logic [sacl_pkg::COUNT_W-1:0]   hits_seen;
  logic [sacl_pkg::COUNT_W-1:0]   misses_seen;
  logic [sacl_pkg::SEED_W-1:0]    victim_lfsr;
  logic [sacl_pkg::OFFSET_W-1:0]  cur_offset;

  lookup_result_t                 lookups_due [$];  // results still owed, oldest first
  logic [sacl_pkg::ADDR_W-1:0]    recent_addrs [$]; // recently sent addresses, reused for hits
  logic [25:0]                    hot_tag_base;     // base of the small tag pool of a phase
  bit                             idle_en;          // allow random gaps on both channels
  int unsigned                    hold_cycles;      // request for one long result hold-off
  int unsigned                    error_count;

  // Clock: 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time; well above the slowest legal run
  initial begin
    #(64'd2_000_000);
    $display("set_assoc_cache_tag_lookup verification failed");
    $finish;
  end

  // Pick a gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Compute the result of one lookup and advance the shadow state
  task automatic predict_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr);
    lookup_result_t                 res;
    logic [sacl_pkg::ADDR_W-1:0]    tag_full;
    logic [25:0]                    tag;
    logic [INDEX_W-1:0]             set;
    logic [sacl_pkg::WAY_OUT_W-1:0] free_ways [NUM_WAYS];
    int unsigned                    n_free;
    res.hit  = 1'b0;
    res.way  = '0;
    tag_full = addr >> (cur_offset + INDEX_W);
    tag      = tag_full[25:0];
    set      = INDEX_W'(addr >> cur_offset);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!res.hit && shadow_valid[set][w] && shadow_tags[set][w] == tag) begin
        res.hit = 1'b1;
        res.way = sacl_pkg::WAY_OUT_W'(w);
      end
    end
    if (res.hit) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      // Victim: pick among invalid ways in ascending order, else among all ways
      n_free = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!shadow_valid[set][w]) begin
          free_ways[n_free] = sacl_pkg::WAY_OUT_W'(w);
          n_free++;
        end
      end
      if (n_free == 0) res.way = sacl_pkg::WAY_OUT_W'(victim_lfsr % NUM_WAYS);
      else res.way = free_ways[victim_lfsr % n_free];
      // Advance the LFSR once per miss: taps 0, 2, 3, 5, shifting right
      victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                     victim_lfsr[15:1]};
      shadow_tags[set][res.way]  = tag;
      shadow_valid[set][res.way] = 1'b1;
      if (misses_seen != '1) misses_seen++;
    end
    res.set_index  = set;
    res.hit_count  = hits_seen;
    res.miss_count = misses_seen;
    lookups_due.push_back(res);
  endtask

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_request(input logic [sacl_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    predict_lookup(addr);
    recent_addrs.push_back(addr);
    if (recent_addrs.size() > RECENT_MAX) void'(recent_addrs.pop_front());
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; only call while the block is idle
  task automatic write_reg(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sacl_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == sacl_pkg::CFG_OFFSET_BITS) begin
      cur_offset = data[sacl_pkg::OFFSET_W-1:0];
    end else if (idx == sacl_pkg::CFG_RANDOM_SEED) begin
      // A zero seed loads the reset value so the LFSR never locks up
      victim_lfsr = (data[sacl_pkg::SEED_W-1:0] != '0) ? data[sacl_pkg::SEED_W-1:0]
                                                       : sacl_pkg::SEED_RESET;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build an address: mostly a few hot tags on a few sets, some reuse, some noise
  function automatic logic [sacl_pkg::ADDR_W-1:0] pick_address();
    int unsigned                 kind;
    logic [sacl_pkg::ADDR_W-1:0] byte_mask;
    logic [sacl_pkg::ADDR_W-1:0] tag;
    logic [sacl_pkg::ADDR_W-1:0] set;
    byte_mask = (32'd1 << cur_offset) - 32'd1;
    kind      = $urandom_range(0, 99);
    if (kind < 20 || recent_addrs.size() == 0) return $urandom();
    if (kind < 45)
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)] ^ ($urandom() & byte_mask);
    tag = 32'(hot_tag_base + 26'($urandom_range(0, 5)));
    set = (kind < 85) ? $urandom_range(0, 3) : $urandom_range(0, NUM_SETS - 1);
    return (tag << (cur_offset + INDEX_W)) | (set << cur_offset) | ($urandom() & byte_mask);
  endfunction

  // Block extremes, same-block hits, fill of one set and replacement in a full set
  task automatic test_basic_lookups();
    logic [sacl_pkg::ADDR_W-1:0] set3_base;
    set3_base = 32'd3 << 5;
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
    send_request(32'h0000_001F);
    // five tags into set 3: four fill free ways, the fifth replaces
    for (int t = 1; t <= 5; t++) send_request((32'(t) << 11) | set3_base);
    for (int t = 1; t <= 5; t++) send_request((32'(t) << 11) | set3_base | 32'h1);
    drain_results();
  endtask

  // Offset at zero, at its top and at 12; stored tags stay as they were
  task automatic test_offset_range();
    write_reg(sacl_pkg::CFG_OFFSET_BITS, sacl_pkg::CFG_DATA_W'(0));
    send_request(32'hFFFF_FFFF);
    drain_results();
    write_reg(sacl_pkg::CFG_OFFSET_BITS, sacl_pkg::CFG_DATA_W'(15));
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
    drain_results();
    write_reg(sacl_pkg::CFG_OFFSET_BITS, sacl_pkg::CFG_DATA_W'(12));
    send_request(32'h1234_5678);
    drain_results();
  endtask

  // Seed extremes, including zero which must fall back to the reset seed
  task automatic test_seed_values();
    logic [sacl_pkg::CFG_DATA_W-1:0] seeds [3];
    seeds = '{sacl_pkg::CFG_DATA_W'(0), sacl_pkg::CFG_DATA_W'(1),
              sacl_pkg::CFG_DATA_W'(16'hFFFF)};
    foreach (seeds[i]) begin
      write_reg(sacl_pkg::CFG_RANDOM_SEED, seeds[i]);
      send_request($urandom());
      send_request($urandom());
      drain_results();
    end
  endtask

  // Random phases, each with its own offset, seed and tag pool
  task automatic test_random_traffic();
    logic [sacl_pkg::OFFSET_W-1:0] offsets [5];
    offsets = '{sacl_pkg::OFFSET_W'(5), sacl_pkg::OFFSET_W'(0), sacl_pkg::OFFSET_W'(15),
                sacl_pkg::OFFSET_W'(12), sacl_pkg::OFFSET_W'($urandom_range(1, 11))};
    foreach (offsets[p]) begin
      drain_results();
      write_reg(sacl_pkg::CFG_OFFSET_BITS, sacl_pkg::CFG_DATA_W'(offsets[p]));
      write_reg(sacl_pkg::CFG_RANDOM_SEED, sacl_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
      hot_tag_base = 26'($urandom());
      // run one phase back to back on both sides
      idle_en = (p != 2);
      repeat (100) send_request(pick_address());
    end
    idle_en = 1'b1;
    drain_results();
  endtask

  // Hold results off for a long stretch while requests keep coming, then pause
  task automatic test_backpressure();
    idle_en     = 1'b0;
    hold_cycles = 300;
    repeat (26) send_request(pick_address());
    drain_results();
    idle_en = 1'b1;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        n = pick_gap();
        out_stall_i <= (n > 0);
        if (n > 1) repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  function automatic void check_field(input string name,
                                      input logic [sacl_pkg::COUNT_W-1:0] want,
                                      input logic [sacl_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every accepted result with the oldest owed one
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookups_due.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = lookups_due.pop_front();
        check_field("hit", sacl_pkg::COUNT_W'(want.hit), sacl_pkg::COUNT_W'(hit_o));
        check_field("way", sacl_pkg::COUNT_W'(want.way), sacl_pkg::COUNT_W'(way_o));
        check_field("set_index", sacl_pkg::COUNT_W'(want.set_index),
                    sacl_pkg::COUNT_W'(set_index_o));
        check_field("hit_count", want.hit_count, hit_count_o);
        check_field("miss_count", want.miss_count, miss_count_o);
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    address_i    <= '0;
    idle_en      = 1'b1;
    hold_cycles  = 0;
    error_count  = 0;
    hot_tag_base = '0;
    // Shadow state after reset: empty cache, counters zero, reset registers
    foreach (shadow_valid[s, w]) begin
      shadow_valid[s][w] = 1'b0;
      shadow_tags[s][w]  = '0;
    end
    hits_seen   = '0;
    misses_seen = '0;
    cur_offset  = sacl_pkg::OFFSET_RESET;
    victim_lfsr = sacl_pkg::SEED_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_lookups();
    test_offset_range();
    test_seed_values();
    test_backpressure();
    test_random_traffic();

    // Let any stray result show up before the verdict
    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("set_assoc_cache_tag_lookup verification clean");
    end else begin
      $display("set_assoc_cache_tag_lookup verification failed");
    end
    $finish;
  end

endmodule
